[sv/indexed_ordered_list_engine_top_defines.svh]
// Assertion macros for the ordered list engine.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef INDEXED_ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define IOE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ioe: implication check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define IOE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ioe: next-cycle check failed");
`else
`define IOE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IOE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[sv/ioe_pkg.sv]
// Package for the ordered list engine: item types, opcodes and cell control.
// No dependencies; used by every module of the engine.
`timescale 1ns / 1ps
`default_nettype none
package ioe_pkg;

  localparam int Capacity = 64;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_END   = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_REM_FRONT = 3'd3;
  localparam logic [2:0] OP_REM_END   = 3'd4;
  localparam logic [2:0] OP_REM_AT    = 3'd5;
  localparam logic [2:0] OP_SEARCH    = 3'd6;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] item_value;
    logic [6:0]         position;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic       found;
    logic [5:0] found_position;
    logic [6:0] entry_count;
  } res_t;

  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_INSERT,
    KIND_REMOVE,
    KIND_SEARCH
  } kind_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
  } ctrl_t;

endpackage
`default_nettype wire

[sv/indexed_ordered_list_engine_top.sv]
// Ordered list engine: a chain of cells keeps up to CAPACITY signed 32-bit values
// in order and takes insert, remove and search commands.
//
// Use: present a command item on cmd_i and raise start; the item is accepted at
// the rising edge where start is high and busy is low. busy stays low, so one
// item may be accepted in every cycle. Each accepted item yields exactly one
// result item on res_o, marked by res_valid_o for a single cycle, in the cycle
// after acceptance; results come out in acceptance order.
// Throughput is one item per cycle. At the accepting edge every cell takes its
// neighbour's value, the new value or its own, so a shift along the whole chain
// is done at once; for a search each cell compares its entry and registers a
// hit bit, and in the result cycle a find-first encoder turns the hit bits into
// the first matching position.
// Reset clears the entry count and the result strobe. The stored entries are not
// cleared and need no clearing pass: only positions below the count are ever read.
// The receiver cannot stall, so no result is ever held back.
// Depends on ioe_pkg, ioe_cell, ioe_ffs and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_ordered_list_engine_top_defines.svh"
module indexed_ordered_list_engine_top
  import ioe_pkg::*;
#(
  parameter int CAPACITY = Capacity
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start,
  output logic  busy,
  input  wire cmd_t cmd_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  // Count width holds CAPACITY itself; compare width also covers the 7-bit position.
  localparam int CntW    = $clog2(CAPACITY + 1);
  localparam int CmpW    = (CntW > 7) ? CntW : 7;
  localparam int IdxW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IdxExtW = (IdxW > 6) ? IdxW : 6;

  logic            accept;
  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] cnt_ext, pos_ext, pos_eff;
  logic            ins_ok, rem_ok, ok;
  ctrl_t           ctrl;

  logic            res_valid_q, res_status_q, res_search_q;

  logic signed [31:0] vals [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [IdxW-1:0]     hit_idx;
  logic                hit_any;
  logic [IdxExtW-1:0]  hit_idx_ext;

  // The engine never needs to hold off a command.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign cnt_ext = CmpW'(count_q);
  assign pos_ext = CmpW'(cmd_i.position);

  // Decode the command into a target position and a validity check.
  always_comb begin
    pos_eff = '0;
    unique case (cmd_i.opcode)
      OP_INS_END: pos_eff = cnt_ext;
      OP_INS_AT:  pos_eff = pos_ext;
      OP_REM_END: pos_eff = cnt_ext - CmpW'(1);
      OP_REM_AT:  pos_eff = pos_ext;
      default:    pos_eff = '0;
    endcase
    ins_ok = (cnt_ext < CmpW'(CAPACITY)) && (pos_eff <= cnt_ext);
    rem_ok = (cnt_ext != '0) && (pos_eff < cnt_ext);

    ctrl.value = cmd_i.item_value;
    ctrl.kind  = KIND_HOLD;
    ok         = 1'b0;
    count_d    = count_q;
    unique case (cmd_i.opcode)
      OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
        ok = ins_ok;
        if (accept && ins_ok) begin
          ctrl.kind = KIND_INSERT;
          count_d   = count_q + CntW'(1);
        end
      end
      OP_REM_FRONT, OP_REM_END, OP_REM_AT: begin
        ok = rem_ok;
        if (accept && rem_ok) begin
          ctrl.kind = KIND_REMOVE;
          count_d   = count_q - CntW'(1);
        end
      end
      OP_SEARCH: begin
        ok = 1'b1;
        if (accept) begin
          ctrl.kind = KIND_SEARCH;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // The chain: each cell sees its neighbours on both sides.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = cmd_i.item_value;
    end else begin : g_inner_l
      assign left_v = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = vals[g];
    end else begin : g_inner_r
      assign right_v = vals[g+1];
    end
    ioe_cell #(
      .Idx  (g),
      .CmpW (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pos_i   (pos_eff),
      .cnt_i   (cnt_ext),
      .left_i  (left_v),
      .right_i (right_v),
      .val_o   (vals[g]),
      .hit_o   (hits[g])
    );
  end

  ioe_ffs #(
    .N (CAPACITY),
    .W (IdxW)
  ) u_ffs (
    .hit_i (hits),
    .idx_o (hit_idx),
    .any_o (hit_any)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= !ok;
      res_search_q <= (cmd_i.opcode == OP_SEARCH);
    end
  end

  // The count register already holds the count after the item now being reported.
  assign hit_idx_ext = IdxExtW'(hit_idx);

  always_comb begin
    res_o.status         = res_status_q;
    res_o.found          = res_search_q && hit_any;
    res_o.found_position = (res_search_q && hit_any) ? hit_idx_ext[5:0] : 6'd0;
    res_o.entry_count    = cnt_ext[6:0];
  end

  assign res_valid_o = res_valid_q;

  `IOE_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(CAPACITY))
  `IOE_ASSERT_NXT(a_result_follows, clk_i, rst_ni, accept, res_valid_o)
  `IOE_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !accept, !res_valid_o)
  `IOE_ASSERT_IMP(a_hits_only_search, clk_i, rst_ni, !res_search_q, hits == '0)
  `IOE_ASSERT_NXT(a_count_step, clk_i, rst_ni, !accept, $stable(count_q))

endmodule
`default_nettype wire

[sv/ioe_cell.sv]
// One storage cell of the ordered list chain.
// Depends on ioe_pkg for the broadcast control struct.
`timescale 1ns / 1ps
`default_nettype none
module ioe_cell
  import ioe_pkg::*;
#(
  parameter int Idx  = 0,
  parameter int CmpW = 7
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire ctrl_t             ctrl_i,
  input  wire       [CmpW-1:0]   pos_i,
  input  wire       [CmpW-1:0]   cnt_i,
  input  wire logic signed [31:0] left_i,
  input  wire logic signed [31:0] right_i,
  output logic signed [31:0]     val_o,
  output logic                   hit_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(Idx);

  logic signed [31:0] val_q, val_d;
  logic               hit_q, hit_d;

  // An insert shifts towards the back from the target on; a remove pulls from the back.
  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.kind)
      KIND_INSERT: begin
        if (MyIdx > pos_i) begin
          val_d = left_i;
        end else if (MyIdx == pos_i) begin
          val_d = ctrl_i.value;
        end
      end
      KIND_REMOVE: begin
        if (MyIdx >= pos_i) begin
          val_d = right_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
    hit_d = (ctrl_i.kind == KIND_SEARCH) && (MyIdx < cnt_i) && (val_q == ctrl_i.value);
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign val_o = val_q;
  assign hit_o = hit_q;

endmodule
`default_nettype wire

[sv/ioe_ffs.sv]
// Find-first-set encoder over the registered hit bits of the cell chain.
// Depends on ioe_pkg for the Capacity default of its parameters.
`timescale 1ns / 1ps
`default_nettype none
module ioe_ffs
  import ioe_pkg::*;
#(
  parameter int N = Capacity,
  parameter int W = $clog2(Capacity)
) (
  input  wire  [N-1:0] hit_i,
  output logic [W-1:0] idx_o,
  output logic         any_o
);

  logic [N-1:0] first;

  // Isolate the lowest set bit, then OR together the indices of the one-hot vector.
  assign first = hit_i & (~hit_i + N'(1));
  assign any_o = |hit_i;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        idx_o = idx_o | W'(i);
      end
    end
  end

endmodule
`default_nettype wire

[bench/tb_indexed_ordered_list_engine_top.sv]
// Self-checking bench for the ordered list engine: random and directed list commands,
// each result checked against a shadow copy of the list kept inside the bench.
// Depends on ioe_pkg and indexed_ordered_list_engine_top.
`timescale 1ns / 1ps
module tb_indexed_ordered_list_engine_top;
  import ioe_pkg::*;

  // The opcode that the engine does not define; it must be ignored.
  localparam logic [2:0] OpUnused      = 3'd7;
  localparam logic       StatusDone    = 1'b0;
  localparam logic       StatusIgnored = 1'b1;
  // Cycles without any handshake before the run is given up.
  localparam int         StallLimit    = 2000;
  localparam int         RandomItems   = 800;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  cmd_t cmd_i  = '0;
  logic res_valid_o;
  res_t res_o;

  // Commands waiting to be presented, and results owed by the engine, oldest first.
  cmd_t cmd_backlog[$];
  res_t due_results[$];

  // Shadow of the list as the engine should hold it.
  logic signed [31:0] shadow_list[Capacity];
  int unsigned        shadow_len = 0;

  int accepted_total = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;

  indexed_ordered_list_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow list operations. An insert shifts everything at and after the
  // position one place back; a remove closes the gap. Both refuse, leaving the
  // list untouched, when the position is out of range or the list is full or
  // empty as the case may be.
  // ---------------------------------------------------------------------------
  function automatic bit shadow_insert(int unsigned pos, logic signed [31:0] value);
    if (shadow_len >= Capacity || pos > shadow_len) return 1'b0;
    for (int i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[pos] = value;
    shadow_len++;
    return 1'b1;
  endfunction

  function automatic bit shadow_remove(int unsigned pos);
    if (pos >= shadow_len) return 1'b0;
    for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
    return 1'b1;
  endfunction

  // Applies one command to the shadow list and returns the result the engine
  // must give for it. Only a search ever reports a hit; the count is the one
  // left after the command.
  function automatic res_t apply_to_list(cmd_t c);
    res_t r;
    bit   ok;
    r  = '0;
    ok = 1'b0;
    case (c.opcode)
      OP_INS_FRONT: ok = shadow_insert(0, c.item_value);
      OP_INS_END:   ok = shadow_insert(shadow_len, c.item_value);
      OP_INS_AT:    ok = shadow_insert(c.position, c.item_value);
      OP_REM_FRONT: ok = shadow_remove(0);
      // Removing from the end of an empty list must not wrap round.
      OP_REM_END:   ok = (shadow_len > 0) ? shadow_remove(shadow_len - 1) : 1'b0;
      OP_REM_AT:    ok = shadow_remove(c.position);
      OP_SEARCH: begin
        ok = 1'b1;
        for (int i = 0; i < shadow_len; i++) begin
          if (!r.found && shadow_list[i] == c.item_value) begin
            r.found          = 1'b1;
            r.found_position = 6'(i);
          end
        end
      end
      default: ok = 1'b0;
    endcase
    r.status      = ok ? StatusDone : StatusIgnored;
    r.entry_count = 7'(shadow_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. At each rising edge it first notes whether the item on the port was
  // taken, then puts up the next one or drops start. Roughly one cycle in five
  // is left empty, except for a quiet stretch in the middle of the run where
  // items follow back to back.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit go;
    go = (accepted_total >= 350 && accepted_total < 500) || ($urandom_range(99) >= 19);
    if (rst_ni) begin
      if (start && !busy) begin
        due_results.push_back(apply_to_list(cmd_i));
        accepted_total++;
      end
      if (start && busy) begin
        // Hold the item until the engine takes it.
      end else if (cmd_backlog.size() != 0 && go) begin
        cmd_i <= cmd_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each strobed result is checked against the oldest owed one.
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("result %p arrived with none owed", res_o));
      end else begin
        want = due_results.pop_front();
        if (res_o.status !== want.status)
          flag_error($sformatf("status expected %0d, got %0d", want.status, res_o.status));
        if (res_o.found !== want.found)
          flag_error($sformatf("found expected %0d, got %0d", want.found, res_o.found));
        if (res_o.found_position !== want.found_position)
          flag_error($sformatf("found_position expected %0d, got %0d",
                               want.found_position, res_o.found_position));
        if (res_o.entry_count !== want.entry_count)
          flag_error($sformatf("entry_count expected %0d, got %0d",
                               want.entry_count, res_o.entry_count));
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("indexed_ordered_list_engine_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input logic [2:0] op, input logic signed [31:0] value,
                           input logic [6:0] pos);
    cmd_t c;
    c.opcode     = op;
    c.item_value = value;
    c.position   = pos;
    cmd_backlog.push_back(c);
  endtask

  // Values are drawn mostly from a small pool so that searches hit and the list
  // holds duplicates; the rest are fully random.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 40) return $urandom;
    case ($urandom_range(9))
      0: return 32'sd0;
      1: return -32'sd1;
      2: return 32'sd1;
      3: return 32'sd2;
      4: return 32'sh7FFF_FFFF;
      5: return 32'sh8000_0000;
      6: return 32'sd42;
      7: return -32'sd42;
      8: return 32'sd1000;
      default: return 32'sh5555_5555;
    endcase
  endfunction

  // Mostly a position the list can hold; now and then one far out of range.
  function automatic logic [6:0] pick_position();
    if ($urandom_range(99) < 88) return 7'($urandom_range(64));
    return 7'($urandom_range(127, 65));
  endfunction

  // A growing stretch is insert-heavy and runs the list up to full; a shrinking
  // stretch is remove-heavy and drains it again.
  function automatic logic [2:0] pick_opcode(bit growing);
    int unsigned r;
    r = $urandom_range(99);
    if (growing) begin
      if (r < 25) return OP_INS_FRONT;
      if (r < 50) return OP_INS_END;
      if (r < 72) return OP_INS_AT;
      if (r < 75) return OP_REM_FRONT;
      if (r < 78) return OP_REM_END;
      if (r < 82) return OP_REM_AT;
      if (r < 98) return OP_SEARCH;
      return OpUnused;
    end
    if (r < 6)  return OP_INS_FRONT;
    if (r < 12) return OP_INS_END;
    if (r < 18) return OP_INS_AT;
    if (r < 38) return OP_REM_FRONT;
    if (r < 58) return OP_REM_END;
    if (r < 80) return OP_REM_AT;
    if (r < 98) return OP_SEARCH;
    return OpUnused;
  endfunction

  // Waits until every queued item has been taken and every result has come.
  task automatic drain();
    while (cmd_backlog.size() != 0 || start || due_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int queued;
    int stretch;
    bit growing;
    bit paused;
    queued  = 0;
    growing = 1'b1;
    paused  = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: removals and a search on the empty list, inserts at both ends,
    // insert at the count and beyond it, searches for the extreme values, the
    // first of two equal values, a removal at the last position, positions far
    // out of range and the undefined opcode.
    queue_cmd(OP_REM_FRONT, 32'sd0, 7'd0);
    queue_cmd(OP_REM_END,   32'sd0, 7'd0);
    queue_cmd(OP_REM_AT,    32'sd0, 7'd0);
    queue_cmd(OP_SEARCH,    32'sd0, 7'd0);
    queue_cmd(OP_INS_END,   32'sh7FFF_FFFF, 7'h7F);
    queue_cmd(OP_INS_FRONT, 32'sh8000_0000, 7'd0);
    queue_cmd(OP_INS_AT,    -32'sd1, 7'd2);
    queue_cmd(OP_INS_AT,    32'sd9, 7'd4);
    queue_cmd(OP_INS_AT,    32'sd0, 7'd1);
    queue_cmd(OP_INS_AT,    -32'sd1, 7'd127);
    queue_cmd(OP_INS_END,   -32'sd1, 7'd0);
    queue_cmd(OP_SEARCH,    -32'sd1, 7'd0);
    queue_cmd(OP_SEARCH,    32'sh8000_0000, 7'd0);
    queue_cmd(OP_SEARCH,    32'sh7FFF_FFFF, 7'd0);
    queue_cmd(OP_SEARCH,    32'sd5, 7'd0);
    queue_cmd(OP_REM_AT,    32'sd0, 7'd4);
    queue_cmd(OP_REM_AT,    32'sd0, 7'd4);
    queue_cmd(OP_REM_AT,    32'sd0, 7'd127);
    queue_cmd(OpUnused,     32'shFFFF_FFFF, 7'h7F);
    queue_cmd(OP_REM_AT,    32'sd0, 7'd1);
    queue_cmd(OP_REM_END,   32'sd0, 7'd0);
    queue_cmd(OP_REM_FRONT, 32'sd0, 7'd0);
    queue_cmd(OP_SEARCH,    32'sd0, 7'd0);
    drain();

    // Random: alternating growing and shrinking stretches of varied length.
    while (queued < RandomItems) begin
      stretch = $urandom_range(160, 60);
      // The last stretch is cut short so that the run stays near its item budget.
      if (stretch > RandomItems - queued) stretch = RandomItems - queued;
      repeat (stretch) begin
        queue_cmd(pick_opcode(growing), pick_value(), pick_position());
      end
      queued += stretch;
      growing = !growing;
      // Once, about half-way, let the engine run dry before going on.
      if (!paused && queued >= RandomItems / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("indexed_ordered_list_engine_top regression: pass");
    end else begin
      $display("indexed_ordered_list_engine_top regression: fail");
    end
    $finish;
  end

endmodule
